// ===== rtl/dtfp_pkg.sv =====
// Package for the decimal text to fixed-point unit.
// Holds the state, command and status types and the fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

  localparam int unsigned ACC_W    = 32;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned FRAC_W   = 3;
  localparam int unsigned PROD_W   = 2 * ACC_W;

  localparam logic [CH_W-1:0]   CODE_ZERO  = 8'd48;
  localparam logic [CH_W-1:0]   CODE_POINT = 8'd46;
  localparam logic [ACC_W-1:0]  ROUND_HALF = 32'd5;
  localparam int unsigned       FRAC_RESET = 1;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [ACC_W-1:0]  RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;

  typedef enum logic {
    ST_IDLE,
    ST_ADJUST
  } dtfp_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CHAR,
    OP_START,
    OP_DIV,
    OP_RND,
    OP_MUL,
    OP_EMIT
  } dtfp_op_t;

  typedef struct packed {
    dtfp_op_t op;
  } dtfp_cmd_t;

  typedef struct packed {
    logic over_by_two;
    logic over;
    logic under;
  } dtfp_status_t;

endpackage

`default_nettype wire

// ===== rtl/dtfp_ctrl.sv =====
// Controller for the decimal text to fixed-point unit.
// Sequences character folds, digit adjustment steps and the result transfer.
// Depends on dtfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_ctrl
  import dtfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_is_end,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire dtfp_status_t status,
  output dtfp_cmd_t         cmd
);

  dtfp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_is_end) state_nxt = ST_ADJUST;
      end
      ST_ADJUST: begin
        if (!status.over && !status.under && out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = in_is_end ? OP_START : OP_CHAR;
      end
      ST_ADJUST: begin
        priority if (status.over_by_two) cmd.op = OP_DIV;
        else if (status.over)            cmd.op = OP_RND;
        else if (status.under)           cmd.op = OP_MUL;
        else if (out_free)               cmd.op = OP_EMIT;
        else                             cmd.op = OP_NONE;
      end
      default: begin
        cmd.op   = OP_NONE;
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = (cmd.op == OP_EMIT) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtfp_datapath.sv =====
// Datapath for the decimal text to fixed-point unit.
// Accumulator, fraction counter, divide/multiply-by-ten step and result register.
// Depends on dtfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_datapath
  import dtfp_pkg::*;
#(
  parameter int unsigned FRAC_COUNT_MAX = 31
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dtfp_cmd_t         cmd,
  input  wire logic [CH_W-1:0]   in_ch,
  input  wire logic              cfg_we,
  input  wire logic [FRAC_W-1:0] cfg_frac_digits,
  output dtfp_status_t           status,
  output logic [ACC_W-1:0]       out_value
);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              point_r, point_nxt;
  logic [FRAC_W-1:0] frac_r;
  logic [ACC_W-1:0]  value_r;

  logic [CNT_W:0]    have_ext, want_ext;
  logic [ACC_W-1:0]  div_in, quot, acc_x10;
  logic [PROD_W-1:0] prod;

  assign have_ext = {1'b0, cnt_r};
  assign want_ext = {{(CNT_W + 1 - FRAC_W){1'b0}}, frac_r};

  assign status.over_by_two = have_ext > (want_ext + (CNT_W + 1)'(1));
  assign status.over        = have_ext > want_ext;
  assign status.under       = want_ext > have_ext;

  assign acc_x10 = (acc_r << 3) + (acc_r << 1);
  assign div_in  = (cmd.op == OP_RND) ? acc_r + ROUND_HALF : acc_r;
  assign prod    = {{ACC_W{1'b0}}, div_in} * {{ACC_W{1'b0}}, RECIP_TEN};
  assign quot    = ACC_W'(prod >> RECIP_SHIFT);

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    point_nxt = point_r;
    unique case (cmd.op)
      OP_CHAR: begin
        if (in_ch == CODE_POINT) begin
          point_nxt = 1'b1;
          cnt_nxt   = '0;
        end else begin
          acc_nxt = acc_x10 + {{(ACC_W - CH_W){1'b0}}, in_ch}
                    - {{(ACC_W - CH_W){1'b0}}, CODE_ZERO};
          if (point_r && (cnt_r < CNT_W'(FRAC_COUNT_MAX))) cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_START: begin
        // count becomes the number of fractional digits on hand
        if (!point_r) cnt_nxt = '0;
      end
      OP_DIV, OP_RND: begin
        acc_nxt = quot;
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_MUL: begin
        acc_nxt = acc_x10;
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_EMIT: begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        point_nxt = 1'b0;
      end
      default: begin
        acc_nxt   = acc_r;
        cnt_nxt   = cnt_r;
        point_nxt = point_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      point_r <= 1'b0;
      frac_r  <= FRAC_W'(FRAC_RESET);
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      point_r <= point_nxt;
      if (cfg_we) frac_r <= cfg_frac_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) value_r <= acc_r;
  end

  assign out_value = value_r;

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_point_unit.sv =====
// Top level of the decimal text to fixed-point unit.
// Joins the controller and the datapath. Depends on dtfp_pkg, dtfp_ctrl, dtfp_datapath.
//
//   Channel  Signals                               Direction  Transfer when
//   in       in_valid in_stall in_ch in_is_end     sink       in_valid && !in_stall
//   out      out_valid out_stall out_value         source     out_valid && !out_stall
//   cfg      cfg_valid cfg_ready cfg_frac_digits   sink       cfg_valid && cfg_ready
//
// A character is taken while idle. A terminator brings |have - want| adjustment steps,
// each a divide by ten (reciprocal multiplier) or multiply by ten (shift and add).
// The result register frees the accumulator: the next number may start while the
// result waits. A terminator can only finish once the result register is free.
// Reset (rst_n, synchronous) clears the number state and sets frac_digits to 1.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_point_unit
  import dtfp_pkg::*;
#(
  parameter int unsigned FRAC_COUNT_MAX = 31
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CH_W-1:0]   in_ch,
  input  wire logic              in_is_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ACC_W-1:0]       out_value,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [FRAC_W-1:0] cfg_frac_digits
);

  dtfp_cmd_t    cmd;
  dtfp_status_t status;

  assign cfg_ready = 1'b1;

  dtfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_is_end (in_is_end),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dtfp_datapath #(
    .FRAC_COUNT_MAX (FRAC_COUNT_MAX)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_ch           (in_ch),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_frac_digits (cfg_frac_digits),
    .status          (status),
    .out_value       (out_value)
  );

endmodule

`default_nettype wire

// ===== bench/tb_decimal_text_to_fixed_point_unit.sv =====
// Self-checking bench for decimal_text_to_fixed_point_unit: directed table, then random numbers.
// Scaled results are predicted in the bench and compared in order as they come out.
// Depends on dtfp_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_point_unit
  import dtfp_pkg::*;
();

  localparam int unsigned FRAC_CNT_MAX = 31;
  localparam int unsigned DIR_ROWS_N = 22;
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             is_end;
    logic             typed;
    logic [ACC_W-1:0] val;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{8'hFF, 1'b1, 1'b1, 32'd0},    // empty number, ch ignored
    '{"4",   1'b0, 1'b0, 32'd0},
    '{"2",   1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 32'd420},  // no point, one digit filled
    '{".",   1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 32'd0},    // point only
    '{"9",   1'b0, 1'b0, 32'd0},
    '{".",   1'b0, 1'b0, 32'd0},
    '{"9",   1'b0, 1'b0, 32'd0},
    '{"5",   1'b0, 1'b0, 32'd0},
    '{8'h7F, 1'b1, 1'b1, 32'd100},  // 9.95 rounds half up
    '{".",   1'b0, 1'b0, 32'd0},
    '{"5",   1'b0, 1'b0, 32'd0},
    '{".",   1'b0, 1'b0, 32'd0},
    '{"2",   1'b0, 1'b0, 32'd0},
    '{"5",   1'b0, 1'b0, 32'd0},
    '{8'h01, 1'b1, 1'b0, 32'd0},    // second point restarts the count
    '{"A",   1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b0, 32'd0},    // non-digit folded in
    '{8'h00, 1'b0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b1, 1'b0, 32'd0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CH_W-1:0]   in_ch;
  logic              in_is_end;
  logic              out_valid;
  logic              out_stall;
  logic [ACC_W-1:0]  out_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [FRAC_W-1:0] cfg_frac_digits;

  decimal_text_to_fixed_point_unit #(
    .FRAC_COUNT_MAX(FRAC_CNT_MAX)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ch(in_ch),
    .in_is_end(in_is_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_frac_digits(cfg_frac_digits)
  );

  // predictor state
  logic [ACC_W-1:0]  num_acc;
  logic [CNT_W-1:0]  num_frac_cnt;
  logic              num_point;
  logic [FRAC_W-1:0] frac_setting;

  logic [ACC_W-1:0]  pending_values[$];
  int unsigned       mismatches;
  int unsigned       items_sent;
  bit                calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_number();
    num_acc = '0;
    num_frac_cnt = '0;
    num_point = 1'b0;
  endfunction

  function automatic void fold_char(logic [CH_W-1:0] c);
    if (c == CODE_POINT) begin
      num_point = 1'b1;
      num_frac_cnt = '0;
    end else begin
      num_acc = num_acc * 32'd10 + {24'd0, c} - {24'd0, CODE_ZERO};
      if (num_point && num_frac_cnt < FRAC_CNT_MAX) num_frac_cnt = num_frac_cnt + 1'b1;
    end
  endfunction

  function automatic logic [ACC_W-1:0] scaled_value();
    logic [ACC_W-1:0] a;
    int unsigned have;
    int unsigned want;
    a = num_acc;
    have = num_point ? num_frac_cnt : 0;
    want = frac_setting;
    while (have > want + 1) begin
      have--;
      a = a / 32'd10;
    end
    if (have > want) begin
      have--;
      a = (a + ROUND_HALF) / 32'd10;
    end
    while (want > have) begin
      have++;
      a = a * 32'd10;
    end
    return a;
  endfunction

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_item(logic [CH_W-1:0] c, logic e, logic typed, logic [ACC_W-1:0] tval);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_ch <= c;
    in_is_end <= e;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (e) begin
      pending_values.push_back(typed ? tval : scaled_value());
      clear_number();
    end else begin
      fold_char(c);
    end
  endtask

  task automatic send_digit();
    send_item(CODE_ZERO + CH_W'($urandom_range(0, 9)), 1'b0, 1'b0, '0);
  endtask

  task automatic send_number();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
      repeat (n) send_digit();
      if ($urandom_range(0, 9) < 7) begin
        send_item(CODE_POINT, 1'b0, 1'b0, '0);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 9);
        repeat (n) begin
          send_digit();
          if ($urandom_range(0, 29) == 0) send_item(CODE_POINT, 1'b0, 1'b0, '0);
        end
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) send_item(CODE_POINT, 1'b0, 1'b0, '0);
        else send_item(CH_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
    end
    send_item(CH_W'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  task automatic write_frac_digits(logic [FRAC_W-1:0] v);
    release_input();
    wait (pending_values.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_frac_digits <= v;
    do @(posedge clk); while (!cfg_ready);
    frac_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall runs, transfers checked at the rising edge
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("unexpected transfer: value actual %0d", out_value);
        mismatches++;
      end else begin
        if (out_value !== pending_values[0]) begin
          $error("value mismatch: expected %0d actual %0d", pending_values[0], out_value);
          mismatches++;
        end
        void'(pending_values.pop_front());
      end
    end
  end

  initial begin
    logic [FRAC_W-1:0] phase_cfg [10];
    int unsigned phase_start;
    phase_cfg = '{3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5, 3'd4, 3'd7, 3'd0, 3'd1};
    mismatches = 0;
    items_sent = 0;
    calm = 1'b0;
    frac_setting = FRAC_W'(FRAC_RESET);
    clear_number();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = '0;
    in_is_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_frac_digits = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      send_item(DIR_ROWS[i].ch, DIR_ROWS[i].is_end, DIR_ROWS[i].typed, DIR_ROWS[i].val);
    end

    for (int p = 0; p < 10; p++) begin
      write_frac_digits(phase_cfg[p]);
      calm = (p == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_number();
        if (p == 4 && items_sent - phase_start >= PHASE_ITEMS / 2 &&
            items_sent - phase_start < PHASE_ITEMS / 2 + 20) begin
          release_input();
          wait (pending_values.size() == 0);
        end
      end
    end
    calm = 1'b0;

    release_input();
    wait (pending_values.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dtfp_pkg.sv
rtl/dtfp_ctrl.sv
rtl/dtfp_datapath.sv
rtl/decimal_text_to_fixed_point_unit.sv
bench/tb_decimal_text_to_fixed_point_unit.sv
